// ===== hw/rtl/sis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ID set package
// Item types and operation/status codes shared by the sorted ID set block.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int KEY_W         = 64;
    localparam int OP_W          = 2;
    localparam int ENTRY_COUNT_W = 7;

    // Operation codes; the unused code behaves as a lookup
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
    } sis_in_t;

    typedef struct packed {
        logic                     was_present;
        logic                     status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } sis_out_t;

endpackage

// ===== hw/rtl/sorted_id_set_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ID set
// Holds up to CAPACITY distinct 64-bit keys in ascending order in a RAM and
// serves insert, lookup and remove items, one result item per input item.
//
//   channel | signals                         | payload
//   --------+---------------------------------+---------------------------
//   input   | in_valid / in_ready / in_data   | operation, key
//   output  | out_valid / out_ready / out_data| was_present, status, count
//
// Each item runs an ascending scan that reads up to the held count of
// entries, then for an insert or remove a shift that moves up to the held
// count of entries; an insert that stores its key adds a store step. The
// worst case is an insert at the front of a table one short of full. The
// single RAM read port and the one 64-bit compare unit handle one entry
// per cycle.
// Reset clears the count and control state only; the table needs no clear.
// A result waits in the output register while the next item is worked; that
// item's result step holds until the earlier result is taken, and in_ready
// stays low meanwhile.
// ----------------------------------------------------------------------------
module sorted_id_set_top #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sis_pkg::sis_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sis_pkg::sis_out_t out_data
);
    import sis_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SHIFT_UP,
        ST_PUT,
        ST_SHIFT_DN,
        ST_RESULT
    } state_t;

    state_t           state_reg,   state_next;
    logic [OP_W-1:0]  op_reg,      op_next;
    logic [KEY_W-1:0] key_reg,     key_next;
    logic [CW-1:0]    count_reg,   count_next;
    logic [CW-1:0]    idx_reg,     idx_next;
    logic [CW-1:0]    pos_reg,     pos_next;
    logic             present_reg, present_next;
    logic             status_reg,  status_next;
    logic             out_valid_reg, out_valid_next;
    sis_out_t         out_data_reg,  out_data_next;

    // Table RAM: one write and one registered read per cycle
    logic [KEY_W-1:0] key_table [CAPACITY];
    logic [KEY_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;

    // Shared compare unit and index arithmetic
    logic          entry_lt;
    logic          entry_eq;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;

    assign entry_lt = rd_data_reg < key_reg;
    assign entry_eq = rd_data_reg == key_reg;
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Hold the table and fetch one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_table[wr_addr] <= wr_data;
        end
        rd_data_reg <= key_table[rd_addr];
    end

    // Sequence scan, shift and result
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        present_next   = present_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data_reg;

        // drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_data.operation;
                    key_next    = in_data.key;
                    status_next = STATUS_OK;
                    if (count_reg == '0)
                    begin
                        pos_next     = '0;
                        present_next = 1'b0;
                        state_next   = ST_DECIDE;
                    end
                    else
                    begin
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                // stop at the first entry not below the key
                if (!entry_lt)
                begin
                    pos_next     = idx_reg;
                    present_next = entry_eq;
                    state_next   = ST_DECIDE;
                end
                else if (idx_inc == count_reg)
                begin
                    pos_next     = count_reg;
                    present_next = 1'b0;
                    state_next   = ST_DECIDE;
                end
                else
                begin
                    rd_addr  = AW'(idx_inc);
                    idx_next = idx_inc;
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_RESULT;
                if (op_reg == OP_INSERT && !present_reg)
                begin
                    if (count_reg == CAP_COUNT)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else if (pos_reg == count_reg)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        rd_addr    = AW'(count_reg - CW'(1));
                        idx_next   = count_reg;
                        state_next = ST_SHIFT_UP;
                    end
                end
                else if (op_reg == OP_REMOVE && present_reg)
                begin
                    if (pos_reg + CW'(1) == count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        rd_addr    = AW'(pos_reg + CW'(1));
                        idx_next   = pos_reg;
                        state_next = ST_SHIFT_DN;
                    end
                end
            end

            ST_SHIFT_UP:
            begin
                // move entry idx-1 up to idx, fetch the next one down
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg);
                if (idx_dec == pos_reg)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    rd_addr  = AW'(idx_reg - CW'(2));
                    idx_next = idx_dec;
                end
            end

            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(pos_reg);
                wr_data    = key_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_RESULT;
            end

            ST_SHIFT_DN:
            begin
                // move entry idx+1 down to idx, fetch the next one up
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg);
                if (idx_reg + CW'(2) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RESULT;
                end
                else
                begin
                    rd_addr  = AW'(idx_reg + CW'(2));
                    idx_next = idx_inc;
                end
            end

            ST_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.was_present = present_reg;
                    out_data_next.status      = status_reg;
                    out_data_next.entry_count = ENTRY_COUNT_W'(count_reg);
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        present_reg  <= present_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // Count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("held count exceeds capacity");

    // An accepted item starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");

    // Table writes happen only in shift and store steps
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SHIFT_UP || state_reg == ST_PUT
                   || state_reg == ST_SHIFT_DN))
        else $error("table write outside shift or store");

    // Storing a key grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT |=> count_reg == $past(count_reg) + CW'(1))
        else $error("store did not bump count");

    // A full status is only reported with a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status == STATUS_FULL
        |-> out_data_reg.entry_count == ENTRY_COUNT_W'(CAP_COUNT))
        else $error("full status with room left");

    // A new result comes only from the result step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result raised outside result step");

endmodule
